// ----- hw/rtl/bb3_pkg.sv -----
// bb3_pkg: shared constants, types and divisor codes for the 3x3 RGB box blur.
// No dependencies; imported by the interfaces, the divider, the top level and the checker.
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 12;
  localparam int CFG_W       = 12;
  localparam int CH_W        = 8;
  localparam int WIN_W       = CH_W + 2;
  localparam int SUM_W       = CH_W + 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(5462);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(3641);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_code_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

endpackage

// ----- hw/rtl/bb3_if.sv -----
// bb3_if: valid/ready stream interfaces for input pixels and blurred results.
// Depends on bb3_pkg.
`timescale 1ns / 1ps

interface bb3_pix_if;
  import bb3_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface bb3_res_if;
  import bb3_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             run_last;
  logic             frame_done;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_col, output run_last, output frame_done,
                  input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_row, input out_col, input run_last, input frame_done,
                  output ready);
endinterface

// ----- hw/rtl/bb3_rdiv.sv -----
// bb3_rdiv: rounded division of a window sum by 4, 6 or 9 (halves round up).
// Reciprocal multiply for 6 and 9, shift for 4. Depends on bb3_pkg.
`timescale 1ns / 1ps

module bb3_rdiv (
  input  logic [bb3_pkg::SUM_W-1:0] sum,
  input  bb3_pkg::div_code_t        code,
  output logic [bb3_pkg::CH_W-1:0]  quo
);
  import bb3_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [SUM_W-1:0]   half;
  logic [RECIP_W-1:0] recip;
  logic [SUM_W-1:0]   x;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    half  = SUM_W'(2);
    recip = '0;
    case (code)
      DIV4: begin
        half  = SUM_W'(2);
      end
      DIV6: begin
        half  = SUM_W'(3);
        recip = RECIP_6;
      end
      DIV9: begin
        half  = SUM_W'(4);
        recip = RECIP_9;
      end
      default: begin
        half  = SUM_W'(2);
      end
    endcase
    x    = sum + half;
    prod = PROD_W'(x) * PROD_W'(recip);
    if (code == DIV4) begin
      quo = x[CH_W+1:2];
    end else begin
      quo = prod[RECIP_SHIFT +: CH_W];
    end
  end

endmodule

// ----- hw/rtl/box_blur_3x3_rgb_unit.sv -----
// box_blur_3x3_rgb_unit: 3x3 box blur over a raster RGB stream, border-clipped window.
// After an item's transfer, S_LOAD forms its window sums; S_EMIT then loads its results into the output register.
// A new item is taken only in S_IDLE, after the line-buffer read/write sequence and the emit loop
//   (one result per cycle while the output is not stalled) have finished with the last one.
// Reset (rst, sync): counters, window and config (640 x 480) cleared; line buffers
//   are not cleared, every entry is written before it feeds a result.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3_pkg::PADDR_W-1:0]   paddr,
  input  logic [bb3_pkg::PDATA_W-1:0]   pwdata,
  output logic [bb3_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  bb3_pix_if.sink                       pix,
  bb3_res_if.source                     res
);
  import bb3_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EMIT
  } state_t;

  localparam int         NSLOT     = 4;
  localparam logic [1:0] LAST_SLOT = 2'd3;
  localparam logic       REG_WIDTH  = 1'b0;
  localparam logic       REG_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] MAXW = CFG_W'(MAX_WIDTH);

  state_t state;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  pixel_t older_mem [MAX_WIDTH];
  pixel_t newer_mem [MAX_WIDTH];
  pixel_t older_q;
  pixel_t newer_q;
  pixel_t px_hold;

  logic [2:0][WIN_W-1:0] win_up0, win_up1, win_lo0, win_lo1;

  logic [NSLOT-1:0]                   slot_en;
  logic [NSLOT-1:0][2:0][SUM_W-1:0]   slot_sum;
  div_code_t                          slot_code [NSLOT];
  logic [NSLOT-1:0][ROW_W-1:0]        slot_row;
  logic [NSLOT-1:0][COL_W-1:0]        slot_col;
  logic [1:0]                         idx;

  logic [NSLOT-1:0]                   slot_en_next;
  logic [NSLOT-1:0][2:0][SUM_W-1:0]   slot_sum_next;
  div_code_t                          slot_code_next [NSLOT];

  logic [CFG_W-1:0] w_eff, h_eff, c_full;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c_idx;
  logic             r_ge1, r_ge2, c_ge1, c_ge2, c_last, last_row;
  logic [2:0][CH_W-1:0]  a_ch, b_ch, p_ch;
  logic [2:0][WIN_W-1:0] cur_lo, cur_up;

  logic             cfg_we, pix_acc, out_free, more_after, emit;
  logic [NSLOT-1:0] above;
  logic [2:0][CH_W-1:0] quo;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_HEIGHT) ? PDATA_W'(frame_height) : PDATA_W'(frame_width);
  assign pix.ready = (state == S_IDLE) && !rst;
  assign pix_acc  = pix.valid && pix.ready;
  assign out_free = !res.valid || res.ready;
  assign emit     = (state == S_EMIT) && slot_en[idx] && out_free;

  always_comb begin
    w_eff = frame_width;
    if (frame_width < CFG_W'(2)) w_eff = CFG_W'(2);
    if (frame_width > MAXW)      w_eff = MAXW;
    h_eff = (frame_height < CFG_W'(2)) ? CFG_W'(2) : frame_height;
    c_full = (CFG_W'(column_count) >= w_eff) ? w_eff - CFG_W'(1) : CFG_W'(column_count);
    r      = (row_count >= h_eff) ? h_eff - CFG_W'(1) : row_count;
    c_idx  = c_full[COL_W-1:0];
    r_ge1  = (r != '0);
    r_ge2  = (r >= ROW_W'(2));
    c_ge1  = (c_full != '0);
    c_ge2  = (c_full >= CFG_W'(2));
    c_last = (c_full == w_eff - CFG_W'(1));
    last_row = (r == h_eff - CFG_W'(1));
  end

  always_comb begin
    a_ch = {older_q.red, older_q.green, older_q.blue};
    b_ch = {newer_q.red, newer_q.green, newer_q.blue};
    p_ch = {px_hold.red, px_hold.green, px_hold.blue};
    for (int k = 0; k < 3; k++) begin
      cur_lo[k] = WIN_W'(b_ch[k]) + WIN_W'(p_ch[k]);
      cur_up[k] = cur_lo[k] + (r_ge2 ? WIN_W'(a_ch[k]) : WIN_W'(0));
    end
  end

  always_comb begin
    slot_en_next = {last_row && c_last, last_row && c_ge1, r_ge1 && c_last, r_ge1 && c_ge1};
    for (int k = 0; k < 3; k++) begin
      slot_sum_next[0][k] = (c_ge2 ? SUM_W'(win_up0[k]) : SUM_W'(0))
                            + SUM_W'(win_up1[k]) + SUM_W'(cur_up[k]);
      slot_sum_next[1][k] = SUM_W'(win_up1[k]) + SUM_W'(cur_up[k]);
      slot_sum_next[2][k] = (c_ge2 ? SUM_W'(win_lo0[k]) : SUM_W'(0))
                            + SUM_W'(win_lo1[k]) + SUM_W'(cur_lo[k]);
      slot_sum_next[3][k] = SUM_W'(win_lo1[k]) + SUM_W'(cur_lo[k]);
    end
    if (c_ge2 && r_ge2)      slot_code_next[0] = DIV9;
    else if (c_ge2 || r_ge2) slot_code_next[0] = DIV6;
    else                     slot_code_next[0] = DIV4;
    slot_code_next[1] = r_ge2 ? DIV6 : DIV4;
    slot_code_next[2] = c_ge2 ? DIV6 : DIV4;
    slot_code_next[3] = DIV4;
  end

  // line buffers: read at transfer, rotate the column in the next cycle (S_LOAD)
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      older_q <= older_mem[c_idx];
      newer_q <= newer_mem[c_idx];
    end
    if (state == S_LOAD) begin
      older_mem[c_idx] <= newer_q;
      newer_mem[c_idx] <= px_hold;
    end
  end

  assign above      = NSLOT'(4'b1110 << idx);
  assign more_after = |(slot_en & above);

  for (genvar k = 0; k < 3; k++) begin : g_div
    bb3_rdiv u_rdiv (
      .sum  (slot_sum[idx][k]),
      .code (slot_code[idx]),
      .quo  (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
      win_up0      <= '0;
      win_up1      <= '0;
      win_lo0      <= '0;
      win_lo1      <= '0;
      slot_en      <= '0;
      idx          <= '0;
      res.valid    <= 1'b0;
    end else begin
      if (res.valid && res.ready && !emit) res.valid <= 1'b0;
      if (cfg_we) begin
        if (paddr[2] == REG_WIDTH) frame_width  <= pwdata[CFG_W-1:0];
        else                       frame_height <= pwdata[CFG_W-1:0];
        column_count <= '0;
        row_count    <= '0;
        win_up0      <= '0;
        win_up1      <= '0;
        win_lo0      <= '0;
        win_lo1      <= '0;
      end
      case (state)
        S_IDLE: begin
          if (pix_acc) begin
            px_hold <= '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          slot_en   <= slot_en_next;
          slot_sum  <= slot_sum_next;
          slot_code <= slot_code_next;
          slot_row  <= {r, r, r - ROW_W'(1), r - ROW_W'(1)};
          slot_col  <= {c_idx, c_idx - COL_W'(1), c_idx, c_idx - COL_W'(1)};
          idx       <= '0;
          win_up0   <= win_up1;
          win_up1   <= cur_up;
          win_lo0   <= win_lo1;
          win_lo1   <= cur_lo;
          if (c_last) begin
            column_count <= '0;
            row_count    <= last_row ? '0 : r + ROW_W'(1);
          end else begin
            column_count <= c_idx + COL_W'(1);
            row_count    <= r;
          end
          state <= (|slot_en_next) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!slot_en[idx]) begin
            if (more_after) idx <= idx + 2'd1;
            else            state <= S_IDLE;
          end else if (out_free) begin
            res.valid      <= 1'b1;
            res.out_red    <= quo[2];
            res.out_green  <= quo[1];
            res.out_blue   <= quo[0];
            res.out_row    <= slot_row[idx];
            res.out_col    <= slot_col[idx];
            res.run_last   <= !more_after;
            res.frame_done <= (idx == LAST_SLOT);
            if (more_after) idx <= idx + 2'd1;
            else            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/bb3_checker.sv -----
// bb3_checker: port-level checks for box_blur_3x3_rgb_unit, attached by bind below.
// Depends on bb3_pkg and the top level's interface ports.
`timescale 1ns / 1ps

module bb3_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pix_valid,
  input logic                      pix_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [bb3_pkg::CH_W-1:0]  out_red,
  input logic [bb3_pkg::CH_W-1:0]  out_green,
  input logic [bb3_pkg::CH_W-1:0]  out_blue,
  input logic [bb3_pkg::ROW_W-1:0] out_row,
  input logic [bb3_pkg::COL_W-1:0] out_col,
  input logic                      run_last,
  input logic                      frame_done
);
  import bb3_pkg::*;

  // one pixel in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("input taken again right after a transfer");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({out_red, out_green, out_blue, out_row, out_col, run_last, frame_done}))
    else $error("stalled result changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_done |-> run_last)
    else $error("frame end not flagged as last of its run");

  a_done_corner: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_done |-> out_row != '0 && out_col != '0)
    else $error("frame end reported away from the bottom-right corner");

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_valid  (pix.valid),
  .pix_ready  (pix.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .out_red    (res.out_red),
  .out_green  (res.out_green),
  .out_blue   (res.out_blue),
  .out_row    (res.out_row),
  .out_col    (res.out_col),
  .run_last   (res.run_last),
  .frame_done (res.frame_done)
);
